// ===== rtl/bpst_pkg.sv =====
`timescale 1ns / 1ps

package bpst_pkg;

    // configuration port geometry
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_MAINS_LIMIT   = 3'd0,
        REG_POWER_DB      = 3'd1,
        REG_MISSING_DB    = 3'd2,
        REG_FREEZE        = 3'd3,
        REG_DROP          = 3'd4,
        REG_RISE_BATT     = 3'd5,
        REG_RISE_MAINS    = 3'd6,
        REG_MISSING_LIMIT = 3'd7
    } bpst_reg_t;

    // register reset values
    localparam logic signed [15:0] RST_MAINS_LIMIT   = 16'sd50;
    localparam logic [31:0]        RST_POWER_DB      = 32'd1200;
    localparam logic [31:0]        RST_MISSING_DB    = 32'd3000;
    localparam logic [31:0]        RST_FREEZE        = 32'd10000;
    localparam logic [31:0]        RST_DROP          = 32'd120000;
    localparam logic [31:0]        RST_RISE_BATT     = 32'd300000;
    localparam logic [31:0]        RST_RISE_MAINS    = 32'd20000;
    localparam logic [14:0]        RST_MISSING_LIMIT = 15'd120;

    // percent limits
    localparam logic signed [7:0] LEVEL_MAX         = 8'sd100;
    localparam logic signed [7:0] LEVEL_MISSING_MAX = 8'sd1;
    localparam logic signed [7:0] NO_PERCENT        = -8'sd1;

    typedef struct packed {
        logic signed [15:0] mains_limit;
        logic [31:0]        power_db;
        logic [31:0]        missing_db;
        logic [31:0]        freeze;
        logic [31:0]        drop;
        logic [31:0]        rise_batt;
        logic [31:0]        rise_mains;
        logic [14:0]        missing_limit;
    } bpst_cfg_t;

    typedef struct packed {
        logic               started;
        logic               mains_flag;
        logic               power_cand_flag;
        logic [31:0]        power_cand_time;
        logic               absent_started;
        logic               absent_cand_flag;
        logic [31:0]        absent_cand_time;
        logic               absent_flag;
        logic               shown_started;
        logic [6:0]         shown_level;
        logic [31:0]        last_step_time;
        logic [31:0]        freeze_until;
    } bpst_state_t;

    typedef struct packed {
        logic [31:0]        time_ms;
        logic signed [7:0]  gauge_level;
        logic signed [15:0] battery_current_ma;
    } bpst_sample_t;

    typedef struct packed {
        logic               mains_powered;
        logic               battery_absent;
        logic               shown_valid;
        logic signed [7:0]  shown_percent;
        logic signed [7:0]  gauge_percent;
    } bpst_result_t;

endpackage

// ===== rtl/bpst_if.sv =====
`timescale 1ns / 1ps

// gauge sample channel
interface bpst_sample_if;
    logic               valid;
    logic               ready;
    logic [31:0]        time_ms;
    logic signed [7:0]  gauge_level;
    logic signed [15:0] battery_current_ma;

    modport source (output valid, output time_ms, output gauge_level,
                    output battery_current_ma, input ready);
    modport sink   (input valid, input time_ms, input gauge_level,
                    input battery_current_ma, output ready);
endinterface

// tracker result channel
interface bpst_result_if;
    logic               valid;
    logic               ready;
    logic               mains_powered;
    logic               battery_absent;
    logic               shown_valid;
    logic signed [7:0]  shown_percent;
    logic signed [7:0]  gauge_percent;

    modport source (output valid, output mains_powered, output battery_absent,
                    output shown_valid, output shown_percent, output gauge_percent,
                    input ready);
    modport sink   (input valid, input mains_powered, input battery_absent,
                    input shown_valid, input shown_percent, input gauge_percent,
                    output ready);
endinterface

// ===== rtl/battery_power_state_tracker_unit.sv =====
`timescale 1ns / 1ps
// channel   | dir | transfer content
// ----------+-----+--------------------------------------------------------------
// sample    | in  | time_ms, gauge_level, battery_current_ma
// result    | out | mains_powered, battery_absent, shown_valid, shown_percent,
//           |     | gauge_percent
// apb       | in  | eight configuration registers at byte address 4*index
//
// one result per sample, carried by the input register, then by the result register
// a new sample is taken every cycle unless the result stalls; the two registers form
// a two-stage pipeline, and the single update stage sets the rate
// tracker state advances when a sample moves from the input register to the result
// register, so the next sample always sees the updated state
// a stalled result holds both stages; sample.ready drops only when both are full
// rst_n clears all tracker state and loads the register defaults

module battery_power_state_tracker_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    bpst_sample_if.sink                   sample,
    bpst_result_if.source                 result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpst_pkg::ADDR_W-1:0]   paddr,
    input  logic [bpst_pkg::DATA_W-1:0]   pwdata,
    output logic [bpst_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    bpst_pkg::bpst_cfg_t    cfg_reg;
    bpst_pkg::bpst_state_t  st_reg;
    bpst_pkg::bpst_state_t  st_next;
    bpst_pkg::bpst_sample_t smp_reg;
    bpst_pkg::bpst_result_t res_reg;
    bpst_pkg::bpst_result_t res_next;
    bpst_pkg::bpst_reg_t    reg_sel;
    logic                   in_full_reg;
    logic                   out_full_reg;
    logic                   advance;
    logic                   cfg_write;

    // pipeline control
    assign advance      = in_full_reg && (!out_full_reg || result.ready);
    assign sample.ready = !in_full_reg || advance;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = bpst_pkg::bpst_reg_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mains_limit   <= bpst_pkg::RST_MAINS_LIMIT;
            cfg_reg.power_db      <= bpst_pkg::RST_POWER_DB;
            cfg_reg.missing_db    <= bpst_pkg::RST_MISSING_DB;
            cfg_reg.freeze        <= bpst_pkg::RST_FREEZE;
            cfg_reg.drop          <= bpst_pkg::RST_DROP;
            cfg_reg.rise_batt     <= bpst_pkg::RST_RISE_BATT;
            cfg_reg.rise_mains    <= bpst_pkg::RST_RISE_MAINS;
            cfg_reg.missing_limit <= bpst_pkg::RST_MISSING_LIMIT;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                bpst_pkg::REG_MAINS_LIMIT:   cfg_reg.mains_limit   <= pwdata[15:0];
                bpst_pkg::REG_POWER_DB:      cfg_reg.power_db      <= pwdata;
                bpst_pkg::REG_MISSING_DB:    cfg_reg.missing_db    <= pwdata;
                bpst_pkg::REG_FREEZE:        cfg_reg.freeze        <= pwdata;
                bpst_pkg::REG_DROP:          cfg_reg.drop          <= pwdata;
                bpst_pkg::REG_RISE_BATT:     cfg_reg.rise_batt     <= pwdata;
                bpst_pkg::REG_RISE_MAINS:    cfg_reg.rise_mains    <= pwdata;
                bpst_pkg::REG_MISSING_LIMIT: cfg_reg.missing_limit <= pwdata[14:0];
                default:                     cfg_reg.freeze        <= cfg_reg.freeze;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_sel)
            bpst_pkg::REG_MAINS_LIMIT:   prdata = {16'd0, cfg_reg.mains_limit};
            bpst_pkg::REG_POWER_DB:      prdata = cfg_reg.power_db;
            bpst_pkg::REG_MISSING_DB:    prdata = cfg_reg.missing_db;
            bpst_pkg::REG_FREEZE:        prdata = cfg_reg.freeze;
            bpst_pkg::REG_DROP:          prdata = cfg_reg.drop;
            bpst_pkg::REG_RISE_BATT:     prdata = cfg_reg.rise_batt;
            bpst_pkg::REG_RISE_MAINS:    prdata = cfg_reg.rise_mains;
            bpst_pkg::REG_MISSING_LIMIT: prdata = {17'd0, cfg_reg.missing_limit};
            default:                     prdata = '0;
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_full_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            smp_reg.time_ms            <= sample.time_ms;
            smp_reg.gauge_level        <= sample.gauge_level;
            smp_reg.battery_current_ma <= sample.battery_current_ma;
        end
    end

    // update stage
    bpst_step u_step (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .smp     (smp_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_full_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = out_full_reg;
    assign result.mains_powered  = res_reg.mains_powered;
    assign result.battery_absent = res_reg.battery_absent;
    assign result.shown_valid    = res_reg.shown_valid;
    assign result.shown_percent  = res_reg.shown_percent;
    assign result.gauge_percent  = res_reg.gauge_percent;

    // checks
    a_shown_not_absent: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.shown_valid && result.battery_absent))
        else $error("shown percent valid while battery absent");

    a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.shown_valid
            ? (result.shown_percent >= 8'sd0 && result.shown_percent <= bpst_pkg::LEVEL_MAX)
            : (result.shown_percent == bpst_pkg::NO_PERCENT)))
        else $error("shown percent out of range");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.shown_level <= bpst_pkg::LEVEL_MAX[6:0])
        else $error("tracked level above full scale");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && out_full_reg && !result.ready) |-> !sample.ready)
        else $error("sample taken while pipeline is full and stalled");

    a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> $stable(st_reg))
        else $error("tracker state changed without a sample");

endmodule

// ===== rtl/bpst_step.sv =====
`timescale 1ns / 1ps

// next state and result for one gauge sample
module bpst_step (
    input  bpst_pkg::bpst_cfg_t    cfg,
    input  bpst_pkg::bpst_state_t  st,
    input  bpst_pkg::bpst_sample_t smp,
    output bpst_pkg::bpst_state_t  st_next,
    output bpst_pkg::bpst_result_t res
);

    logic        on_mains;
    logic        freeze_load;
    logic [31:0] power_elapsed;
    logic [31:0] absent_elapsed;
    logic [31:0] step_elapsed;
    logic [31:0] freeze_diff;
    logic [31:0] freeze_neg;
    logic        frozen;
    logic        level_ok;
    logic        level_low;
    logic [16:0] cur_mag;
    logic        absent_raw;
    logic [6:0]  target;
    logic [31:0] rise_need;
    logic        shown_ok;

    assign on_mains       = smp.battery_current_ma <= cfg.mains_limit;
    assign power_elapsed  = smp.time_ms - st.power_cand_time;
    assign absent_elapsed = smp.time_ms - st.absent_cand_time;
    assign step_elapsed   = smp.time_ms - st.last_step_time;
    assign freeze_diff    = smp.time_ms - st.freeze_until;
    assign freeze_neg     = 32'd0 - cfg.freeze;

    assign level_ok  = (smp.gauge_level >= 8'sd0) && (smp.gauge_level <= bpst_pkg::LEVEL_MAX);
    // negative levels clamp to zero, so a signed compare covers the clamp
    assign level_low = smp.gauge_level <= bpst_pkg::LEVEL_MISSING_MAX;
    assign cur_mag   = smp.battery_current_ma[15]
                       ? 17'd0 - {smp.battery_current_ma[15], smp.battery_current_ma}
                       : {1'b0, smp.battery_current_ma};
    assign target    = smp.gauge_level[6:0];

    always_comb
    begin
        st_next     = st;
        freeze_load = 1'b0;

        // power source debounce
        if (!st.started)
        begin
            st_next.started         = 1'b1;
            st_next.mains_flag      = on_mains;
            st_next.power_cand_flag = on_mains;
            st_next.power_cand_time = smp.time_ms;
            freeze_load             = 1'b1;
        end
        else if (on_mains != st.mains_flag)
        begin
            if (on_mains != st.power_cand_flag)
            begin
                st_next.power_cand_flag = on_mains;
                st_next.power_cand_time = smp.time_ms;
            end
            else if (power_elapsed >= cfg.power_db)
            begin
                st_next.mains_flag = st.power_cand_flag;
                freeze_load        = 1'b1;
            end
        end
        else
        begin
            st_next.power_cand_flag = on_mains;
            st_next.power_cand_time = smp.time_ms;
        end

        if (freeze_load)
        begin
            st_next.freeze_until = smp.time_ms + cfg.freeze;
        end

        // missing battery debounce
        absent_raw = st_next.mains_flag && level_low && (cur_mag <= {2'b00, cfg.missing_limit});
        if (!st.absent_started)
        begin
            st_next.absent_started   = 1'b1;
            st_next.absent_flag      = absent_raw;
            st_next.absent_cand_flag = absent_raw;
            st_next.absent_cand_time = smp.time_ms;
        end
        else if (absent_raw != st.absent_cand_flag)
        begin
            st_next.absent_cand_flag = absent_raw;
            st_next.absent_cand_time = smp.time_ms;
        end
        else if ((st.absent_cand_flag != st.absent_flag) && (absent_elapsed >= cfg.missing_db))
        begin
            st_next.absent_flag = st.absent_cand_flag;
        end

        // a freshly loaded window ends at now + freeze
        frozen    = freeze_load ? freeze_neg[31] : freeze_diff[31];
        rise_need = st_next.mains_flag ? cfg.rise_mains : cfg.rise_batt;

        // displayed percent rate limiter
        if (!st.shown_started && level_ok)
        begin
            st_next.shown_started  = 1'b1;
            st_next.shown_level    = target;
            st_next.last_step_time = smp.time_ms;
        end
        else if (st.shown_started && level_ok && !st_next.absent_flag && !frozen)
        begin
            if (target < st.shown_level)
            begin
                if (!st_next.mains_flag && (step_elapsed >= cfg.drop))
                begin
                    st_next.shown_level    = st.shown_level - 7'd1;
                    st_next.last_step_time = smp.time_ms;
                end
            end
            else if (target > st.shown_level)
            begin
                if (step_elapsed >= rise_need)
                begin
                    st_next.shown_level    = st.shown_level + 7'd1;
                    st_next.last_step_time = smp.time_ms;
                end
            end
        end

        // result fields
        shown_ok           = st_next.shown_started && !st_next.absent_flag;
        res.mains_powered  = st_next.mains_flag;
        res.battery_absent = st_next.absent_flag;
        res.shown_valid    = shown_ok;
        res.shown_percent  = shown_ok ? $signed({1'b0, st_next.shown_level})
                                      : bpst_pkg::NO_PERCENT;
        res.gauge_percent  = level_ok ? smp.gauge_level : bpst_pkg::NO_PERCENT;
    end

endmodule
